// ===== design/stepper_ramp_segment_generator_core_defines.svh =====
// ---------------------------------------------------------------------------
// Stepper ramp segment generator - assertion macros
// Shared helpers for the concurrent checks at the end of the core.
// ---------------------------------------------------------------------------
`ifndef STEPPER_RAMP_SEGMENT_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_SEGMENT_GENERATOR_CORE_DEFINES_SVH

// Check sampled on the rising clock edge, masked while reset is held.
`define SRSG_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that also holds across reset.
`define SRSG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/srsg_pkg.sv =====
// ---------------------------------------------------------------------------
// srsg_pkg
// Widths, command codes and the divider interface types of the ramp core.
// ---------------------------------------------------------------------------
package srsg_pkg;

    localparam int FUNC_W   = 2;
    localparam int FREQ_W   = 16;
    localparam int SECS_W   = 8;
    localparam int STEP_W   = 6;
    localparam int PULSE_W  = 24;
    localparam int COUNT_W  = 25;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 2;

    localparam int DEF_MAX_RAMP_STEPS = 63;

    // divider operand widths
    localparam int DIV_W    = PULSE_W;
    localparam int DIVR_W   = STEP_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [FUNC_W-1:0] FUNC_SOFT_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SOFT_STOP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PULSE_MOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED     = 2'd3;

    localparam logic [DIVR_W-1:0] THIRDS_DIVISOR = 6'd3;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== design/srsg_div.sv =====
// ---------------------------------------------------------------------------
// srsg_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ---------------------------------------------------------------------------
module srsg_div
    import srsg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    divr_reg, divr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    logic [DIVR_W:0]      rem_sh;
    logic                 ge;
    logic [DIVR_W:0]      diff;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, divr_reg};
    assign diff   = rem_sh - {1'b0, divr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        divr_next = divr_reg;
        quo_next  = quo_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            divr_next = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        divr_reg <= divr_next;
        quo_reg  <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/stepper_ramp_segment_generator_core.sv =====
// ---------------------------------------------------------------------------
// stepper_ramp_segment_generator_core
// Turns motion commands into a list of speed segments.
// ---------------------------------------------------------------------------
// Each accepted command other than an unused code produces one or more segments
// (frequency plus edge or pulse count). Ramp commands and the three-part pulse
// move first run one division through the shared bit-serial divider: accept,
// divide, take the quotient, then one segment per cycle while m_tready is held
// high. Commands that need no division (single pulse move, zero-step ramps, soft
// starts with no rise or no hold time) go straight to the segments. The input is
// not ready until the last segment of a command has been loaded into the output
// register; an unused command code is dropped.
`include "stepper_ramp_segment_generator_core_defines.svh"

module stepper_ramp_segment_generator_core
    import srsg_pkg::*;
#(
    parameter int MAX_RAMP_STEPS = DEF_MAX_RAMP_STEPS
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // func[1:0], start_freq[17:2], end_freq[33:18], hold_seconds[41:34],
    // ramp_steps[47:42], pulse_total[71:48]
    input  logic [S_DATA_W-1:0] s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // seg_freq[15:0], seg_count[40:16], zero fill [47:41]
    output logic [M_DATA_W-1:0] m_tdata,
    // continuous[0], stop_after[1]
    output logic [M_USER_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(MAX_RAMP_STEPS);

    logic [1:0]          state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [FREQ_W-1:0]   f1_reg, f1_next;
    logic [SECS_W-1:0]   secs_reg, secs_next;
    logic [STEP_W-1:0]   n_reg, n_next;
    logic                three_reg, three_next;
    logic [PULSE_W-1:0]  pulses_reg, pulses_next;
    logic [DIV_W-1:0]    q_reg, q_next;
    logic [FREQ_W-1:0]   f_reg, f_next;
    logic [STEP_W-1:0]   i_reg, i_next;

    logic                m_valid_reg, m_valid_next;
    logic [FREQ_W-1:0]   o_freq_reg, o_freq_next;
    logic [COUNT_W-1:0]  o_count_reg, o_count_next;
    logic                o_cont_reg, o_cont_next;
    logic                o_stop_reg, o_stop_next;
    logic                o_last_reg, o_last_next;

    // input fields
    logic [FUNC_W-1:0]   in_func;
    logic [FREQ_W-1:0]   in_f0, in_f1;
    logic [SECS_W-1:0]   in_secs;
    logic [STEP_W-1:0]   in_steps, in_n;
    logic [PULSE_W-1:0]  in_pulses;

    assign in_func   = s_tdata[1:0];
    assign in_f0     = s_tdata[17:2];
    assign in_f1     = s_tdata[33:18];
    assign in_secs   = s_tdata[41:34];
    assign in_steps  = s_tdata[47:42];
    assign in_pulses = s_tdata[71:48];
    assign in_n      = (in_steps > MAX_STEPS) ? MAX_STEPS : in_steps;

    div_req_t div_req;
    div_rsp_t div_rsp;

    srsg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // segment under construction
    logic [COUNT_W-1:0]  prod;
    logic [PULSE_W-1:0]  mid_pulses;
    logic [FREQ_W-1:0]   seg_freq;
    logic [COUNT_W-1:0]  seg_count;
    logic                seg_cont, seg_stop, seg_last;
    logic                fin;

    assign prod       = COUNT_W'({f_reg, 1'b0}) * COUNT_W'(secs_reg);
    assign mid_pulses = pulses_reg - {q_reg[PULSE_W-2:0], 1'b0};
    assign fin        = (i_reg == n_reg - 1'b1);

    always_comb begin
        seg_freq  = f_reg;
        seg_count = prod;
        seg_cont  = 1'b0;
        seg_stop  = 1'b0;
        seg_last  = 1'b0;
        f_next    = f_reg;
        case (func_reg)
            FUNC_SOFT_START: begin
                if (i_reg == n_reg) begin
                    seg_freq  = f1_reg;
                    seg_count = '0;
                    seg_cont  = 1'b1;
                    seg_last  = 1'b1;
                end else begin
                    f_next = f_reg + q_reg[FREQ_W-1:0];
                end
            end
            FUNC_SOFT_STOP: begin
                if (n_reg == '0) begin
                    seg_freq  = '0;
                    seg_count = '0;
                    seg_stop  = 1'b1;
                    seg_last  = 1'b1;
                end else begin
                    seg_stop = fin;
                    seg_last = fin;
                    f_next   = f_reg - q_reg[FREQ_W-1:0];
                end
            end
            FUNC_PULSE_MOVE: begin
                if (three_reg) begin
                    if (i_reg == STEP_W'(1)) begin
                        seg_freq  = f1_reg;
                        seg_count = COUNT_W'(mid_pulses);
                    end else begin
                        seg_freq  = {1'b0, f1_reg[FREQ_W-1:1]};
                        seg_count = COUNT_W'(q_reg);
                        seg_stop  = (i_reg == STEP_W'(2));
                        seg_last  = (i_reg == STEP_W'(2));
                    end
                end else begin
                    seg_freq  = f1_reg;
                    seg_count = COUNT_W'(pulses_reg);
                    seg_stop  = 1'b1;
                    seg_last  = 1'b1;
                end
            end
            default: begin
                seg_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        f1_next      = f1_reg;
        secs_next    = secs_reg;
        n_next       = n_reg;
        three_next   = three_reg;
        pulses_next  = pulses_reg;
        q_next       = q_reg;
        i_next       = i_reg;
        m_valid_next = m_valid_reg;
        o_freq_next  = o_freq_reg;
        o_count_next = o_count_reg;
        o_cont_next  = o_cont_reg;
        o_stop_next  = o_stop_reg;
        o_last_next  = o_last_reg;
        div_req      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next   = in_func;
                    f1_next     = in_f1;
                    secs_next   = in_secs;
                    pulses_next = in_pulses;
                    three_next  = (in_steps == STEP_W'(1));
                    n_next      = in_n;
                    i_next      = '0;
                    case (in_func)
                        FUNC_SOFT_START: begin
                            if (in_f0 >= in_f1 || in_secs == '0 || in_n == '0) begin
                                n_next     = '0;
                                state_next = ST_EMIT;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_W'(in_f1 - in_f0);
                                div_req.divisor  = in_n;
                                state_next       = ST_DIV;
                            end
                        end
                        FUNC_SOFT_STOP: begin
                            if (in_n == '0) begin
                                state_next = ST_EMIT;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_W'(in_f0);
                                div_req.divisor  = in_n;
                                state_next       = ST_DIV;
                            end
                        end
                        FUNC_PULSE_MOVE: begin
                            if (in_steps == STEP_W'(1)) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = in_pulses;
                                div_req.divisor  = THIRDS_DIVISOR;
                                state_next       = ST_DIV;
                            end else begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    q_next     = div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_freq_next  = seg_freq;
                    o_count_next = seg_count;
                    o_cont_next  = seg_cont;
                    o_stop_next  = seg_stop;
                    o_last_next  = seg_last;
                    i_next       = i_reg + 1'b1;
                    if (seg_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic [FREQ_W-1:0] f_load;
    assign f_load = (state_reg == ST_IDLE) ? in_f0 :
                    ((state_reg == ST_EMIT) && (!m_valid_reg || m_tready)) ? f_next : f_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg    <= func_next;
        f1_reg      <= f1_next;
        secs_reg    <= secs_next;
        n_reg       <= n_next;
        three_reg   <= three_next;
        pulses_reg  <= pulses_next;
        q_reg       <= q_next;
        f_reg       <= f_load;
        i_reg       <= i_next;
        o_freq_reg  <= o_freq_next;
        o_count_reg <= o_count_next;
        o_cont_reg  <= o_cont_next;
        o_stop_reg  <= o_stop_next;
        o_last_reg  <= o_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - COUNT_W - FREQ_W){1'b0}}, o_count_reg, o_freq_reg};
    assign m_tuser  = {o_stop_reg, o_cont_reg};
    assign m_tlast  = o_last_reg;

    `SRSG_ASSERT(a_div_only_in_div, aclk, aresetn, div_rsp.busy |-> state_reg == ST_DIV, "divider busy outside divide state")
    `SRSG_ASSERT(a_ramp_below_end, aclk, aresetn, (state_reg == ST_EMIT && func_reg == FUNC_SOFT_START && i_reg != n_reg) |-> f_reg < f1_reg, "soft start ramp frequency reached end frequency early")
    `SRSG_ASSERT(a_no_accept_while_busy, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready || $past(in_func) == FUNC_UNUSED, "input ready right after a valid command transfer")
    `SRSG_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

// ===== bench/stepper_ramp_segment_generator_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_ramp_segment_generator_core_test
// Self-checking bench for the ramp segment core. Motion commands are sent on
// the slave stream. A predictor expands each accepted command into its speed
// segments, and every segment on the master stream is checked against the
// oldest one still expected. Both sides idle in random bursts. One directed
// set of commands runs first, then a random mix biased toward valid ramps.
// ---------------------------------------------------------------------------
module stepper_ramp_segment_generator_core_test;
    import srsg_pkg::*;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_total;
        logic [STEP_W-1:0]  ramp_steps;
        logic [SECS_W-1:0]  hold_seconds;
        logic [FREQ_W-1:0]  end_freq;
        logic [FREQ_W-1:0]  start_freq;
        logic [FUNC_W-1:0]  func;
    } motion_cmd_t;

    typedef struct {
        logic [FREQ_W-1:0]  freq;
        logic [COUNT_W-1:0] count;
        logic               continuous;
        logic               stop_after;
        logic               last;
    } segment_t;

    localparam int RANDOM_CMDS  = 185;
    localparam int DRAIN_CYCLES = 64;

    class segment_scoreboard;
        segment_t expected_segments[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction

        function void add_segment(logic [31:0] freq, logic [31:0] count, logic cont,
                                  logic stop, logic last);
            segment_t s;
            s.freq       = freq[FREQ_W-1:0];
            s.count      = count[COUNT_W-1:0];
            s.continuous = cont;
            s.stop_after = stop;
            s.last       = last;
            expected_segments.push_back(s);
        endfunction

        // expand one accepted command into the segments it must produce
        function void note_command(motion_cmd_t c);
            logic [31:0] f;
            logic [31:0] delta;
            logic [31:0] secs;
            logic [31:0] p3;
            int unsigned n;
            int unsigned i;
            n    = 32'(c.ramp_steps);
            secs = 32'(c.hold_seconds);
            if (n > DEF_MAX_RAMP_STEPS)
                n = DEF_MAX_RAMP_STEPS;
            case (c.func)
                FUNC_SOFT_START: begin
                    if (c.start_freq >= c.end_freq || c.hold_seconds == 0)
                        n = 0;
                    delta = (n != 0) ? (32'(c.end_freq) - 32'(c.start_freq)) / n : 32'd0;
                    f = 32'(c.start_freq);
                    for (i = 0; i < n; i++) begin
                        add_segment(f, f * 32'd2 * secs, 1'b0, 1'b0, 1'b0);
                        f += delta;
                    end
                    add_segment(32'(c.end_freq), 32'd0, 1'b1, 1'b0, 1'b1);
                end
                FUNC_SOFT_STOP: begin
                    if (n == 0) begin
                        add_segment(32'd0, 32'd0, 1'b0, 1'b1, 1'b1);
                    end else begin
                        delta = 32'(c.start_freq) / n;
                        f = 32'(c.start_freq);
                        for (i = 0; i < n; i++) begin
                            add_segment(f, f * 32'd2 * secs, 1'b0,
                                        i + 1 == n, i + 1 == n);
                            f -= delta;
                        end
                    end
                end
                FUNC_PULSE_MOVE: begin
                    if (c.ramp_steps == 1) begin
                        p3 = 32'(c.pulse_total) / 32'd3;
                        add_segment(32'(c.end_freq) / 32'd2, p3, 1'b0, 1'b0, 1'b0);
                        add_segment(32'(c.end_freq), 32'(c.pulse_total) - 32'd2 * p3,
                                    1'b0, 1'b0, 1'b0);
                        add_segment(32'(c.end_freq) / 32'd2, p3, 1'b0, 1'b1, 1'b1);
                    end else begin
                        add_segment(32'(c.end_freq), 32'(c.pulse_total), 1'b0, 1'b1, 1'b1);
                    end
                end
                default: ;  // unused code: dropped by the core
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t exp_s;
            if (expected_segments.size() == 0) begin
                errors++;
                $display("%0t: unexpected segment, expected none, actual freq %0d count %0d",
                         $time, got.freq, got.count);
                return;
            end
            exp_s = expected_segments.pop_front();
            compare_field("seg_freq", 32'(exp_s.freq), 32'(got.freq));
            compare_field("seg_count", 32'(exp_s.count), 32'(got.count));
            compare_field("continuous", 32'(exp_s.continuous), 32'(got.continuous));
            compare_field("stop_after", 32'(exp_s.stop_after), 32'(got.stop_after));
            compare_field("last", 32'(exp_s.last), 32'(got.last));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    bit                  allow_idle = 1'b1;
    segment_scoreboard   sb = new();

    stepper_ramp_segment_generator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // segment sink: check each transfer, stall in random bursts
    initial begin
        segment_t got;
        int       stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.freq       = m_tdata[15:0];
                got.count      = m_tdata[40:16];
                got.continuous = m_tuser[0];
                got.stop_after = m_tuser[1];
                got.last       = m_tlast;
                sb.check_segment(got);
            end
            if (stall_left > 0 && allow_idle) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                stall_left = 0;
                m_tready <= 1'b1;
            end
        end
    end

    function motion_cmd_t make_cmd(logic [FUNC_W-1:0] func, logic [FREQ_W-1:0] f0,
                                   logic [FREQ_W-1:0] f1, logic [SECS_W-1:0] secs,
                                   logic [STEP_W-1:0] steps, logic [PULSE_W-1:0] pulses);
        motion_cmd_t c;
        c.func         = func;
        c.start_freq   = f0;
        c.end_freq     = f1;
        c.hold_seconds = secs;
        c.ramp_steps   = steps;
        c.pulse_total  = pulses;
        return c;
    endfunction

    function motion_cmd_t random_command();
        motion_cmd_t    c;
        logic [FREQ_W-1:0] tmp;
        int unsigned    pick;
        c = S_DATA_W'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 38)
            c.func = FUNC_SOFT_START;
        else if (pick < 66)
            c.func = FUNC_SOFT_STOP;
        else if (pick < 93)
            c.func = FUNC_PULSE_MOVE;
        else
            c.func = FUNC_UNUSED;
        if ($urandom_range(0, 3) == 0) begin
            c.start_freq = FREQ_W'($urandom_range(0, 300));
            c.end_freq   = FREQ_W'($urandom_range(0, 300));
        end
        // most ramps go up so that the stepped part is reached
        if (c.func == FUNC_SOFT_START && $urandom_range(0, 9) < 8 &&
            c.start_freq > c.end_freq) begin
            tmp          = c.start_freq;
            c.start_freq = c.end_freq;
            c.end_freq   = tmp;
        end
        if ($urandom_range(0, 9) == 0)
            c.hold_seconds = '0;
        if ($urandom_range(0, 4) != 0)
            c.ramp_steps = STEP_W'($urandom_range(0, 8));
        if (c.func == FUNC_PULSE_MOVE && $urandom_range(0, 1) == 0)
            c.ramp_steps = STEP_W'(1);
        return c;
    endfunction

    task automatic send_command(motion_cmd_t c);
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_command(c);
    endtask

    task automatic maybe_gap();
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        motion_cmd_t directed[$];
        motion_cmd_t c;
        int          n_sent;
        int          k;

        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd0, 16'hFFFF, 8'hFF, 6'd63, 24'hFFFFFF));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd100, 16'd5000, 8'd3, 6'd0, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd1000, 16'd1000, 8'd4, 6'd5, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'hFFFF, 16'd0, 8'd4, 6'd5, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd10, 16'd900, 8'd0, 6'd7, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd100, 16'd200, 8'd1, 6'd3, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd0, 16'd1, 8'd2, 6'd1, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_START, 16'd5, 16'd9, 8'd1, 6'd63, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_STOP, 16'd4000, 16'd0, 8'd2, 6'd0, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_STOP, 16'hFFFF, 16'hFFFF, 8'hFF, 6'd63, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_STOP, 16'd10, 16'd0, 8'd9, 6'd63, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_STOP, 16'd777, 16'd0, 8'd1, 6'd1, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_STOP, 16'd0, 16'd0, 8'd0, 6'd4, 24'd0));
        directed.push_back(make_cmd(FUNC_PULSE_MOVE, 16'd0, 16'hFFFF, 8'd0, 6'd1, 24'hFFFFFF));
        directed.push_back(make_cmd(FUNC_PULSE_MOVE, 16'd0, 16'd1, 8'd0, 6'd1, 24'd5));
        directed.push_back(make_cmd(FUNC_PULSE_MOVE, 16'd0, 16'd300, 8'd0, 6'd1, 24'd0));
        directed.push_back(make_cmd(FUNC_PULSE_MOVE, 16'd0, 16'd301, 8'd0, 6'd1, 24'd2));
        directed.push_back(make_cmd(FUNC_PULSE_MOVE, 16'hFFFF, 16'd1234, 8'hFF, 6'd0,
                                    24'hFFFFFF));
        directed.push_back(make_cmd(FUNC_PULSE_MOVE, 16'd0, 16'd0, 8'd0, 6'd63, 24'd0));
        directed.push_back(make_cmd(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 6'd63,
                                    24'hFFFFFF));
        directed.push_back(make_cmd(FUNC_UNUSED, 16'd0, 16'd0, 8'd0, 6'd0, 24'd0));
        directed.push_back(make_cmd(FUNC_SOFT_STOP, 16'd50, 16'd0, 8'd3, 6'd2, 24'd0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            maybe_gap();
            send_command(directed[i]);
        end
        wait_drained();

        n_sent = 0;
        k      = 0;
        while (n_sent < RANDOM_CMDS) begin
            // a calm stretch in the middle and a clean tail at the end
            allow_idle = !((n_sent >= 70 && n_sent < 100) || n_sent >= RANDOM_CMDS - 40);
            if (k > 0 && k % 50 == 0)
                wait_drained();
            else
                maybe_gap();
            c = random_command();
            send_command(c);
            if (c.func != FUNC_UNUSED)
                n_sent++;
            k++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("stepper_ramp_segment_generator_core regression: pass");
        else
            $display("stepper_ramp_segment_generator_core regression: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("stepper_ramp_segment_generator_core regression: fail");
        $finish;
    end

endmodule
